>>> hdl/sra_pkg.sv
package sra_pkg;

  localparam int NUM_DIRS   = 8;
  localparam int BOARD_BITS = 64;

  localparam logic [1:0] OP_ORTH = 2'd0;
  localparam logic [1:0] OP_DIAG = 2'd1;

  // Direction order: N, S, E, W, NE, NW, SE, SW.
  localparam int DIR_FILE [NUM_DIRS] = '{0, 0, 1, -1, 1, -1, 1, -1};
  localparam int DIR_RANK [NUM_DIRS] = '{1, -1, 0, 0, 1, 1, -1, -1};

  // Rays whose squares lie at increasing bit indexes as they move outward.
  localparam logic [NUM_DIRS-1:0] DIR_POSITIVE = 8'b0011_0101;
  localparam logic [NUM_DIRS-1:0] DIR_DIAG     = 8'b1111_0000;

  typedef logic [NUM_DIRS-1:0][BOARD_BITS-1:0] ray_vec_t;

  // Per-ray squares and blockers; rays that run toward lower indexes are
  // kept bit-reversed so every stage can search from the low end.
  typedef struct packed {
    ray_vec_t ray;
    ray_vec_t blk;
  } ray_bus_t;

  function automatic logic [BOARD_BITS-1:0] ray_mask(input logic [5:0] sq,
                                                      input logic [2:0] dir);
    logic [BOARD_BITS-1:0] m;
    int f;
    int r;
    int s;
    logic live;
    m    = '0;
    f    = int'(sq[2:0]);
    r    = int'(sq[5:3]);
    live = 1'b1;
    for (s = 1; s < 8; s++) begin
      f = f + DIR_FILE[dir];
      r = r + DIR_RANK[dir];
      if (f < 0 || f > 7 || r < 0 || r > 7) begin
        live = 1'b0;
      end
      if (live) begin
        m[r*8+f] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [BOARD_BITS-1:0] bit_rev(input logic [BOARD_BITS-1:0] v);
    logic [BOARD_BITS-1:0] o;
    int i;
    for (i = 0; i < BOARD_BITS; i++) begin
      o[i] = v[BOARD_BITS-1-i];
    end
    return o;
  endfunction

endpackage

>>> hdl/sra_ray_decode.sv
module sra_ray_decode import sra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_operation,
  input  logic [5:0]            in_square,
  input  logic [BOARD_BITS-1:0] in_occupancy,
  output logic                  s1_valid_r,
  output ray_bus_t              s1_bus_r
);

  ray_bus_t bus_nxt;
  logic     orth;
  logic     diag;

  assign orth = (in_operation != OP_DIAG);
  assign diag = (in_operation != OP_ORTH);

  always_comb begin
    logic [BOARD_BITS-1:0] ray;
    logic [BOARD_BITS-1:0] blk;
    logic                  en;
    for (int d = 0; d < NUM_DIRS; d++) begin
      en  = DIR_DIAG[d] ? diag : orth;
      ray = en ? ray_mask(in_square, d[2:0]) : '0;
      blk = ray & in_occupancy;
      if (DIR_POSITIVE[d]) begin
        bus_nxt.ray[d] = ray;
        bus_nxt.blk[d] = blk;
      end else begin
        bus_nxt.ray[d] = bit_rev(ray);
        bus_nxt.blk[d] = bit_rev(blk);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_bus_r <= bus_nxt;
  end

endmodule

>>> hdl/sra_blocker_isolate.sv
module sra_blocker_isolate import sra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s1_valid,
  input  ray_bus_t s1_bus,
  output logic     s2_valid_r,
  output ray_bus_t s2_bus_r
);

  ray_bus_t bus_nxt;

  // Keep only the nearest blocker of each ray (lowest set bit).
  always_comb begin
    for (int d = 0; d < NUM_DIRS; d++) begin
      bus_nxt.ray[d] = s1_bus.ray[d];
      bus_nxt.blk[d] = s1_bus.blk[d] & (~s1_bus.blk[d] + {{(BOARD_BITS-1){1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_bus_r <= bus_nxt;
  end

endmodule

>>> hdl/sra_reach_merge.sv
module sra_reach_merge import sra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s2_valid,
  input  ray_bus_t              s2_bus,
  output logic                  out_valid_r,
  output logic [BOARD_BITS-1:0] out_reach_set_r
);

  logic [BOARD_BITS-1:0] reach_nxt;

  // With no blocker the isolated bit is zero and the mask covers the whole ray.
  always_comb begin
    logic [BOARD_BITS-1:0] upto;
    logic [BOARD_BITS-1:0] part;
    reach_nxt = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      upto = s2_bus.blk[d] ^ (s2_bus.blk[d] - {{(BOARD_BITS-1){1'b0}}, 1'b1});
      part = s2_bus.ray[d] & upto;
      if (DIR_POSITIVE[d]) begin
        reach_nxt = reach_nxt | part;
      end else begin
        reach_nxt = reach_nxt | bit_rev(part);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_reach_set_r <= reach_nxt;
  end

endmodule

>>> hdl/sliding_ray_attack_generator.sv
// Each start is carried through the stage registers to out_reach_set with out_valid.
// Throughput: one item per cycle through three register stages (ray lookup,
// nearest-blocker isolation, reach merge); busy is always low.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous active-low reset clears the stage valid bits only.
module sliding_ray_attack_generator import sra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_operation,
  input  logic [5:0]            in_square,
  input  logic [BOARD_BITS-1:0] in_occupancy,
  output logic                  out_valid,
  output logic [BOARD_BITS-1:0] out_reach_set
);

  logic     s1_valid;
  ray_bus_t s1_bus;
  logic     s2_valid;
  ray_bus_t s2_bus;

  assign busy = 1'b0;

  sra_ray_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start),
    .in_operation (in_operation),
    .in_square    (in_square),
    .in_occupancy (in_occupancy),
    .s1_valid_r   (s1_valid),
    .s1_bus_r     (s1_bus)
  );

  sra_blocker_isolate u_isolate (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_bus     (s1_bus),
    .s2_valid_r (s2_valid),
    .s2_bus_r   (s2_bus)
  );

  sra_reach_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .s2_valid        (s2_valid),
    .s2_bus          (s2_bus),
    .out_valid_r     (out_valid),
    .out_reach_set_r (out_reach_set)
  );

  // Every accepted item yields exactly one result.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
      |-> (out_valid == $past(start, 3)))
    else $error("result strobe does not match accepted item");

  // The origin square is never part of the reach set.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
      |-> (out_reach_set[$past(in_square, 3)] == 1'b0))
    else $error("origin square present in reach set");

  // With the orthogonal rays selected alone, no square on the NE diagonal ray is reached.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
      && ($past(in_operation, 3) == OP_ORTH))
      |-> ((out_reach_set & ray_mask($past(in_square, 3), 3'd4)) == '0))
    else $error("diagonal square reached by orthogonal operation");

endmodule

>>> sim/tb_sliding_ray_attack_generator.sv
`timescale 1ns / 1ps

module tb_sliding_ray_attack_generator;
  import sra_pkg::*;

  localparam logic [1:0] OP_BOTH  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [63:0] BOARD_EMPTY  = 64'h0;
  localparam logic [63:0] BOARD_FULL   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BOARD_BORDER = 64'hFF81_8181_8181_81FF;

  localparam int PIPE_DEPTH  = 3;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_operation;
  logic [5:0]            in_square;
  logic [BOARD_BITS-1:0] in_occupancy;
  logic                  out_valid;
  logic [BOARD_BITS-1:0] out_reach_set;

  logic [63:0] pending_reach [$];
  int          fail_count;
  int          cycle_count;
  int          gap_max;

  sliding_ray_attack_generator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_square    (in_square),
    .in_occupancy (in_occupancy),
    .out_valid    (out_valid),
    .out_reach_set(out_reach_set)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walks each of the eight rays that op selects, from the origin; the first occupied square
  // ends a ray and is still part of the reach set.
  function automatic logic [63:0] predict_reach(input logic [1:0] op,
                                                input logic [5:0] sq,
                                                input logic [63:0] occ);
    logic [63:0] reach;
    logic        want_orth;
    logic        want_diag;
    logic        blocked;
    int          df;
    int          dr;
    int          f;
    int          r;
    reach     = '0;
    want_orth = (op != OP_DIAG);
    want_diag = (op != OP_ORTH);
    for (df = -1; df <= 1; df++) begin
      for (dr = -1; dr <= 1; dr++) begin
        if ((df != 0 || dr != 0) &&
            (((df == 0 || dr == 0) && want_orth) || (df != 0 && dr != 0 && want_diag))) begin
          f       = int'(sq[2:0]) + df;
          r       = int'(sq[5:3]) + dr;
          blocked = 1'b0;
          while (!blocked && f >= 0 && f <= 7 && r >= 0 && r <= 7) begin
            reach[r*8+f] = 1'b1;
            blocked      = occ[r*8+f];
            f            = f + df;
            r            = r + dr;
          end
        end
      end
    end
    return reach;
  endfunction

  function automatic logic [63:0] random_board();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] board;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: board = a & b & c;
      1: board = a & b;
      2: board = a;
      default: board = a | b;
    endcase
    return board;
  endfunction

  function automatic logic [1:0] random_operation();
    logic [1:0] op;
    if ($urandom_range(0, 9) == 0) begin
      op = OP_SPARE;
    end else begin
      op = 2'($urandom_range(0, 2));
    end
    return op;
  endfunction

  task automatic issue_query(input logic [1:0] op, input logic [5:0] sq,
                             input logic [63:0] occ);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start        = 1'b1;
    in_operation = op;
    in_square    = sq;
    in_occupancy = occ;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_reach.size() != 0) @(negedge clk);
  endtask

  task automatic test_board_edges();
    issue_query(OP_ORTH, 6'd0, BOARD_EMPTY);
    issue_query(OP_DIAG, 6'd63, BOARD_EMPTY);
    issue_query(OP_BOTH, 6'd7, BOARD_EMPTY);
    issue_query(OP_BOTH, 6'd56, BOARD_EMPTY);
    issue_query(OP_DIAG, 6'd3, BOARD_EMPTY);
    issue_query(OP_ORTH, 6'd24, 64'hAAAA_AAAA_AAAA_AAAA);
    issue_query(OP_BOTH, 6'd39, 64'h5555_5555_5555_5555);
  endtask

  task automatic test_blockers();
    issue_query(OP_BOTH, 6'd56, BOARD_FULL);
    issue_query(OP_ORTH, 6'd27, BOARD_FULL);
    issue_query(OP_DIAG, 6'd36, 64'h1 << 36);
    issue_query(OP_BOTH, 6'd36, ~(64'h1 << 36));
    issue_query(OP_ORTH, 6'd60, ~(64'h1 << 60));
    issue_query(OP_ORTH, 6'd18, BOARD_BORDER);
    issue_query(OP_DIAG, 6'd45, BOARD_BORDER);
  endtask

  task automatic test_unused_operation();
    issue_query(OP_SPARE, 6'd35, BOARD_EMPTY);
    issue_query(OP_SPARE, 6'd0, BOARD_FULL);
    issue_query(OP_SPARE, 6'd28, random_board());
    issue_query(OP_SPARE, 6'd63, BOARD_BORDER);
  endtask

  task automatic test_random_queries(input int count);
    repeat (count) begin
      issue_query(random_operation(), 6'($urandom_range(0, 63)), random_board());
    end
  endtask

  // Items at full rate, start held high across consecutive items.
  task automatic test_back_to_back(input int count);
    int saved_gap;
    saved_gap = gap_max;
    gap_max   = 0;
    test_random_queries(count);
    gap_max   = saved_gap;
  endtask

  always @(posedge clk) begin : check_results
    logic [63:0] expected;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_reach.size() == 0) begin
          $error("reach_set result %h with no item outstanding", out_reach_set);
          fail_count++;
        end else begin
          expected = pending_reach.pop_front();
          if (out_reach_set !== expected) begin
            $error("reach_set mismatch: expected %h, actual %h", expected, out_reach_set);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_reach.push_back(predict_reach(in_operation, in_square, in_occupancy));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_ray_attack_generator verification failed");
      $finish;
    end
  end

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    gap_max      = 4;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_ORTH;
    in_square    = '0;
    in_occupancy = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_board_edges();
    test_blockers();
    test_unused_operation();
    wait_for_results();

    test_random_queries(900);
    test_back_to_back(200);
    wait_for_results();
    test_random_queries(850);

    wait_for_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending_reach.size() != 0) begin
      $error("%0d reach_set results never arrived", pending_reach.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("sliding_ray_attack_generator verification clean");
    end else begin
      $display("sliding_ray_attack_generator verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sra_pkg.sv
hdl/sra_ray_decode.sv
hdl/sra_blocker_isolate.sv
hdl/sra_reach_merge.sv
hdl/sliding_ray_attack_generator.sv
sim/tb_sliding_ray_attack_generator.sv
